// ===== src/hdfd_pkg.sv =====
package hdfd_pkg;

    localparam logic [7:0] HDR_MID = 8'd23;
    localparam logic [7:0] FTR_ESC = 8'd9;
    localparam logic [7:0] FTR_END = 8'd12;

    // One result word
    typedef struct packed {
        logic [7:0] data;
        logic       done;
        logic       last;
    } t_res;

    // Results caused by one input word: cnt of them, r0 first
    typedef struct packed {
        logic [1:0] cnt;
        t_res       r0;
        t_res       r1;
    } t_res_pair;

endpackage

// ===== src/header_footer_byte_deframer_unit.sv =====
// Results: a word's results are written into the result queue registers at the edge
//   that accepts it and leave on the master side in order, behind any results waiting.
// Throughput: one input word per cycle while each word yields at most one result and
//   the master side takes results; a word that yields two results drops tready in the
//   next cycle, and tready stays low while two or more results wait in the three-entry result queue.
// Reset (synchronous, active low): parser back to header hunt, result queue empty,
//   device id cleared to 0.
module header_footer_byte_deframer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration: device id
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    // slave side
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] rx_byte
    // master side
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tuser,   // [0] frame_done
    output logic       o_m_axis_tlast    // last_of_run
);

    logic [7:0]          r_dev_id;
    logic                w_accept;
    logic                w_room;
    hdfd_pkg::t_res_pair w_res;
    hdfd_pkg::t_res      w_head;

    // Hold the device id; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_id <= 8'd0;
        end else if (i_cfg_we) begin
            r_dev_id <= i_cfg_wdata;
        end
    end

    // Take a word whenever the queue has room for the worst case of two results
    assign o_s_axis_tready = w_room;
    assign w_accept        = i_s_axis_tvalid && w_room;

    // Header hunt / payload / footer escape state machine
    hdfd_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_s_axis_tdata),
        .i_dev_id (r_dev_id),
        .o_res    (w_res)
    );

    // Result registers: decouple master-side stalls from the input
    hdfd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_res   (w_res),
        .o_room  (w_room),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_head  (w_head)
    );

    assign o_m_axis_tdata = w_head.data;
    assign o_m_axis_tuser = w_head.done;
    assign o_m_axis_tlast = w_head.last;

    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == 8'd0 && o_m_axis_tlast)
        else $error("frame end result carries data or lacks last");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_res.cnt == 2'd2 |-> !w_res.r0.last && w_res.r1.last
            && w_res.r0.data == hdfd_pkg::FTR_ESC)
        else $error("escaped pair out of order");

    a_no_third: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.cnt != 2'd3)
        else $error("more than two results for one word");

endmodule

// ===== src/hdfd_parse.sv =====
module hdfd_parse (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_byte,
    input  logic [7:0]           i_dev_id,
    output hdfd_pkg::t_res_pair  o_res
);

    typedef enum logic [2:0] {
        ST_HUNT = 3'd0,
        ST_ID   = 3'd1,
        ST_MID  = 3'd2,
        ST_DATA = 3'd3,
        ST_ESC  = 3'd4
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_tail_ok;

    // 9-bit compare so that an id of 255 never completes the header
    assign w_tail_ok = ({1'b0, i_byte} == ({1'b0, i_dev_id} + 9'd1));

    always_comb begin
        n_state      = r_state;
        o_res.cnt    = 2'd0;
        o_res.r0     = '0;
        o_res.r1     = '0;
        unique case (r_state)
            ST_HUNT: begin
                if (i_byte == i_dev_id) begin
                    n_state = ST_ID;
                end
            end
            ST_ID: begin
                if (i_byte == hdfd_pkg::HDR_MID) begin
                    n_state = ST_MID;
                end else if (i_byte != i_dev_id) begin
                    n_state = ST_HUNT;
                end
            end
            ST_MID: begin
                n_state = w_tail_ok ? ST_DATA : ST_HUNT;
            end
            ST_DATA: begin
                if (i_byte == hdfd_pkg::FTR_ESC) begin
                    n_state = ST_ESC;
                end else begin
                    o_res.cnt = 2'd1;
                    o_res.r0  = '{data: i_byte, done: 1'b0, last: 1'b1};
                end
            end
            ST_ESC: begin
                if (i_byte == hdfd_pkg::FTR_END) begin
                    o_res.cnt = 2'd1;
                    o_res.r0  = '{data: 8'd0, done: 1'b1, last: 1'b1};
                    n_state   = ST_HUNT;
                end else if (i_byte == hdfd_pkg::FTR_ESC) begin
                    o_res.cnt = 2'd1;
                    o_res.r0  = '{data: hdfd_pkg::FTR_ESC, done: 1'b0, last: 1'b1};
                end else begin
                    o_res.cnt = 2'd2;
                    o_res.r0  = '{data: hdfd_pkg::FTR_ESC, done: 1'b0, last: 1'b0};
                    o_res.r1  = '{data: i_byte, done: 1'b0, last: 1'b1};
                    n_state   = ST_DATA;
                end
            end
            default: begin
                n_state = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
        end else if (i_accept) begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/hdfd_outq.sv =====
module hdfd_outq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  hdfd_pkg::t_res_pair  i_res,
    output logic                 o_room,
    output logic                 o_valid,
    input  logic                 i_ready,
    output hdfd_pkg::t_res       o_head
);

    hdfd_pkg::t_res r_q [3];
    hdfd_pkg::t_res n_q [3];
    logic [1:0]     r_cnt;
    logic [1:0]     n_cnt;
    logic           w_pop;
    logic [1:0]     w_base;
    logic [1:0]     w_add;

    assign w_pop   = (r_cnt != 2'd0) && i_ready;
    assign w_base  = r_cnt - {1'b0, w_pop};
    assign w_add   = i_push ? i_res.cnt : 2'd0;
    // Room for a two-result word, decided from registered count only
    assign o_room  = (r_cnt <= 2'd1);
    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_q[0];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            // shift down on pop
            if (w_pop && k < 2) begin
                n_q[k] = r_q[k + 1];
            end else begin
                n_q[k] = r_q[k];
            end
            if (w_add != 2'd0 && w_base == 2'(k)) begin
                n_q[k] = i_res.r0;
            end
            if (w_add == 2'd2 && ({1'b0, w_base} + 3'd1) == 3'(k)) begin
                n_q[k] = i_res.r1;
            end
        end
        n_cnt = w_base + w_add;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        for (int k = 0; k < 3; k++) begin
            r_q[k] <= n_q[k];
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && i_res.cnt == 2'd2 |-> r_cnt <= 2'd1)
        else $error("result queue overflow");

endmodule
